>>> design/aaline_pkg.sv
// aaline_pkg: shared constants and types for the antialiased line pixel generator
// depends on nothing; used by antialiased_line_pixel_generator

package aaline_pkg;

    localparam int COORD_W       = 16;   // input coordinate width, signed Q12.4
    localparam int COORD_FRAC    = 4;
    localparam int SLOPE_FRAC    = 16;
    localparam int COVER_BITS    = 8;
    localparam int PIX_W         = 13;   // pixel coordinate width
    localparam int FIX_W         = 32;   // minor values with SLOPE_FRAC fraction bits
    localparam int DIFF_W        = COORD_W + 1;
    localparam int QUO_W         = SLOPE_FRAC + 1;
    localparam int GRAD_W        = QUO_W + 1;
    localparam int REM_W         = DIFF_W + 1;
    localparam int DIV_STEPS     = SLOPE_FRAC + 1;
    localparam int CNT_W         = $clog2(DIV_STEPS);
    localparam int WGT_W         = COVER_BITS + 1;

    localparam logic kind_start   = 1'b0;
    localparam logic kind_advance = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIV   = 10'b00_0000_0010,
        S_GRAD  = 10'b00_0000_0100,
        S_ENDS  = 10'b00_0000_1000,
        S_W0    = 10'b00_0001_0000,
        S_W1    = 10'b00_0010_0000,
        S_A0    = 10'b00_0100_0000,
        S_A1    = 10'b00_1000_0000,
        S_SEND0 = 10'b01_0000_0000,
        S_SEND1 = 10'b10_0000_0000
    } aaline_state_t;

endpackage

>>> design/antialiased_line_pixel_generator.sv
// antialiased_line_pixel_generator: wu-style antialiased line rasterizer
// depends on aaline_pkg (constants, state type)
//
//  channel | dir | tdata fields (lsb up)                         | tuser | tlast
//  s_      | in  | x_start y_start x_end y_end red green blue alpha| kind  | -
//  m_      | out | pixel_x pixel_y pixel_red/green/blue/alpha, pad| -     | last_pixel
//
// a start word is accepted while idle, then restoring division forms the
// gradient (one quotient bit per cycle through one subtractor), S_GRAD sets the
// gradient sign and S_ENDS does the endpoint setup, the shared 9x9 multiplier
// gives the two weights and alphas (S_W0, S_W1, S_A0, S_A1), then 2 output words.
// an advance word goes through S_W0 to S_A1 and the two output words; output may stall.
// s_tready is high only while idle; a stalled output word holds until taken.
// aresetn is synchronous and clears the control state and line flags.

module antialiased_line_pixel_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // x_start, y_start, x_end, y_end, red, green, blue, alpha
    input  logic        s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue,
                                   // pixel_alpha, zero pad
    output logic        m_tlast    // last_pixel
);

    localparam int CW  = aaline_pkg::COORD_W;
    localparam int DW  = aaline_pkg::DIFF_W;
    localparam int PW  = aaline_pkg::PIX_W;
    localparam int FW  = aaline_pkg::FIX_W;
    localparam int GW  = aaline_pkg::GRAD_W;
    localparam int QW  = aaline_pkg::QUO_W;
    localparam int RW  = aaline_pkg::REM_W;
    localparam int WW  = aaline_pkg::WGT_W;
    localparam int NW  = aaline_pkg::CNT_W;

    aaline_pkg::aaline_state_t state_reg, state_next;

    // line state
    logic                 active_reg, active_next;
    logic                 steep_reg, steep_next;
    logic                 far_pend_reg, far_pend_next;
    logic signed [PW-1:0] cursor_reg, cursor_next;
    logic signed [PW-1:0] stop_reg, stop_next;
    logic signed [FW-1:0] icpt_reg, icpt_next;
    logic signed [GW-1:0] slope_reg, slope_next;
    logic signed [FW-1:0] far_minor_reg, far_minor_next;
    logic [7:0]           far_gap_reg, far_gap_next;
    logic [31:0]          colour_reg, colour_next;

    // start setup and divider
    logic signed [CW-1:0] mi1_reg, mi1_next, mi2_reg, mi2_next;
    logic signed [DW-1:0] t1_reg, t1_next, t2_reg, t2_next;   // endpoint major + half
    logic [DW-1:0]        dma_reg, dma_next;
    logic                 neg_reg, neg_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        quo_reg, quo_next;
    logic [NW-1:0]        cnt_reg, cnt_next;

    // pair in flight
    logic signed [PW-1:0] pm_major_reg, pm_major_next;
    logic signed [FW-1:0] pm_minor_reg, pm_minor_next;
    logic [WW-1:0]        pm_gap_reg, pm_gap_next;
    logic                 pm_last_reg, pm_last_next;
    logic [WW-1:0]        w0_reg, w0_next, w1_reg, w1_next;
    logic [7:0]           a0_reg, a0_next, a1_reg, a1_next;

    // input fields
    logic signed [CW-1:0] x1, y1, x2, y2;
    logic signed [DW-1:0] dx, dy, ma1, mi1e, ma2, mi2e, dmi;
    logic [DW-1:0]        adx, ady;
    logic                 steep_in, swap;
    logic signed [CW-1:0] sa1, sb1, sa2, sb2;

    // divider step
    logic [RW-1:0]        div_r;
    logic                 div_ge;

    // endpoint setup
    logic signed [4:0]    o1, o2;
    logic signed [GW+4:0] p1, p2;
    logic signed [FW-1:0] mq1, mq2;

    // shared multiplier
    logic [WW-1:0]        mul_a, mul_b;
    logic [2*WW-1:0]      mul_p;
    logic [7:0]           frac;
    logic [WW-1:0]        rfrac;

    // output word
    logic signed [PW-1:0] base, px_minor, px_x, px_y;
    logic signed [PW:0]   cur_ext;

    assign x1 = s_tdata[15:0];
    assign y1 = s_tdata[31:16];
    assign x2 = s_tdata[47:32];
    assign y2 = s_tdata[63:48];

    always_comb begin
        dx       = DW'(x2) - DW'(x1);
        dy       = DW'(y2) - DW'(y1);
        adx      = dx[DW-1] ? DW'(-dx) : dx;
        ady      = dy[DW-1] ? DW'(-dy) : dy;
        steep_in = !(adx > ady);
        sa1      = steep_in ? y1 : x1;
        sb1      = steep_in ? x1 : y1;
        sa2      = steep_in ? y2 : x2;
        sb2      = steep_in ? x2 : y2;
        swap     = sa2 < sa1;
        ma1      = DW'(swap ? sa2 : sa1);
        ma2      = DW'(swap ? sa1 : sa2);
        mi1e     = DW'(swap ? sb2 : sb1);
        mi2e     = DW'(swap ? sb1 : sb2);
        dmi      = mi2e - mi1e;
    end

    // one restoring step: shift (except first step), compare, subtract
    always_comb begin
        div_r  = (cnt_reg == '0) ? rem_reg : {rem_reg[RW-2:0], 1'b0};
        div_ge = div_r >= RW'(dma_reg);
    end

    // endpoint minor values: offset to pixel center is 8 minus the low nibble
    always_comb begin
        o1  = 5'sd8 - $signed({1'b0, t1_reg[3:0]});
        o2  = 5'sd8 - $signed({1'b0, t2_reg[3:0]});
        p1  = slope_reg * o1;
        p2  = slope_reg * o2;
        mq1 = {{4{mi1_reg[CW-1]}}, mi1_reg, 12'b0} + {{13{p1[GW+4]}}, p1[GW+4:4]};
        mq2 = {{4{mi2_reg[CW-1]}}, mi2_reg, 12'b0} + {{13{p2[GW+4]}}, p2[GW+4:4]};
    end

    // coverage of the pair's first pixel
    assign frac  = pm_minor_reg[15:8];
    assign rfrac = WW'(9'd256) - {1'b0, frac};

    always_comb begin
        unique case (state_reg)
            aaline_pkg::S_W0: begin
                mul_a = rfrac;
                mul_b = pm_gap_reg;
            end
            aaline_pkg::S_W1: begin
                mul_a = {1'b0, frac};
                mul_b = pm_gap_reg;
            end
            aaline_pkg::S_A0: begin
                mul_a = {1'b0, colour_reg[31:24]};
                mul_b = w0_reg;
            end
            aaline_pkg::S_A1: begin
                mul_a = {1'b0, colour_reg[31:24]};
                mul_b = w1_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    assign cur_ext = {cursor_reg[PW-1], cursor_reg};

    always_comb begin
        state_next     = state_reg;
        active_next    = active_reg;
        steep_next     = steep_reg;
        far_pend_next  = far_pend_reg;
        cursor_next    = cursor_reg;
        stop_next      = stop_reg;
        icpt_next      = icpt_reg;
        slope_next     = slope_reg;
        far_minor_next = far_minor_reg;
        far_gap_next   = far_gap_reg;
        colour_next    = colour_reg;
        mi1_next       = mi1_reg;
        mi2_next       = mi2_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        dma_next       = dma_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        pm_major_next  = pm_major_reg;
        pm_minor_next  = pm_minor_reg;
        pm_gap_next    = pm_gap_reg;
        pm_last_next   = pm_last_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        a0_next        = a0_reg;
        a1_next        = a1_reg;

        unique case (state_reg)
            aaline_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == aaline_pkg::kind_start) begin
                        steep_next  = steep_in;
                        colour_next = s_tdata[95:64];
                        mi1_next    = CW'(mi1e);
                        mi2_next    = CW'(mi2e);
                        t1_next     = ma1 + DW'(8);
                        t2_next     = ma2 + DW'(8);
                        dma_next    = ma2 - ma1;
                        neg_next    = dmi[DW-1];
                        rem_next    = RW'(dmi[DW-1] ? DW'(-dmi) : dmi);
                        quo_next    = '0;
                        cnt_next    = '0;
                        state_next  = aaline_pkg::S_DIV;
                    end else if (active_reg) begin
                        if (far_pend_reg) begin
                            far_pend_next = 1'b0;
                            pm_major_next = stop_reg;
                            pm_minor_next = far_minor_reg;
                            pm_gap_next   = {1'b0, far_gap_reg};
                            pm_last_next  = !(cursor_reg < stop_reg);
                            if (!(cursor_reg < stop_reg)) begin
                                active_next = 1'b0;
                            end
                        end else begin
                            pm_major_next = cursor_reg;
                            pm_minor_next = icpt_reg;
                            pm_gap_next   = WW'(9'd256);
                            icpt_next     = icpt_reg + FW'(slope_reg);
                            cursor_next   = cursor_reg + PW'(1);
                            pm_last_next  = (cur_ext + 14'sd1) >=
                                            $signed({stop_reg[PW-1], stop_reg});
                            if ((cur_ext + 14'sd1) >= $signed({stop_reg[PW-1], stop_reg})) begin
                                active_next = 1'b0;
                            end
                        end
                        state_next = aaline_pkg::S_W0;
                    end
                end
            end
            aaline_pkg::S_DIV: begin
                rem_next = div_ge ? RW'(div_r - RW'(dma_reg)) : div_r;
                quo_next = {quo_reg[QW-2:0], div_ge};
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == NW'(aaline_pkg::DIV_STEPS - 1)) begin
                    state_next = aaline_pkg::S_GRAD;
                end
            end
            aaline_pkg::S_GRAD: begin
                if (dma_reg == '0) begin
                    slope_next = '0;
                end else if (neg_reg) begin
                    slope_next = -$signed({1'b0, quo_reg});
                end else begin
                    slope_next = $signed({1'b0, quo_reg});
                end
                state_next = aaline_pkg::S_ENDS;
            end
            aaline_pkg::S_ENDS: begin
                pm_major_next  = t1_reg[DW-1:4];
                pm_minor_next  = mq1;
                pm_gap_next    = WW'(9'd256) - {1'b0, t1_reg[3:0], 4'b0};
                pm_last_next   = 1'b0;
                icpt_next      = mq1 + FW'(slope_reg);
                far_minor_next = mq2;
                far_gap_next   = {t2_reg[3:0], 4'b0};
                cursor_next    = t1_reg[DW-1:4] + PW'(1);
                stop_next      = t2_reg[DW-1:4];
                far_pend_next  = 1'b1;
                active_next    = 1'b1;
                state_next     = aaline_pkg::S_W0;
            end
            aaline_pkg::S_W0: begin
                w0_next    = mul_p[WW+7:8];
                state_next = aaline_pkg::S_W1;
            end
            aaline_pkg::S_W1: begin
                w1_next    = mul_p[WW+7:8];
                state_next = aaline_pkg::S_A0;
            end
            aaline_pkg::S_A0: begin
                a0_next    = mul_p[15:8];
                state_next = aaline_pkg::S_A1;
            end
            aaline_pkg::S_A1: begin
                a1_next    = mul_p[15:8];
                state_next = aaline_pkg::S_SEND0;
            end
            aaline_pkg::S_SEND0: begin
                if (m_tready) begin
                    state_next = aaline_pkg::S_SEND1;
                end
            end
            aaline_pkg::S_SEND1: begin
                if (m_tready) begin
                    state_next = aaline_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = aaline_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= aaline_pkg::S_IDLE;
            active_reg   <= 1'b0;
            far_pend_reg <= 1'b0;
            steep_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            far_pend_reg <= far_pend_next;
            steep_reg    <= steep_next;
        end
    end

    always_ff @(posedge aclk) begin
        cursor_reg    <= cursor_next;
        stop_reg      <= stop_next;
        icpt_reg      <= icpt_next;
        slope_reg     <= slope_next;
        far_minor_reg <= far_minor_next;
        far_gap_reg   <= far_gap_next;
        colour_reg    <= colour_next;
        mi1_reg       <= mi1_next;
        mi2_reg       <= mi2_next;
        t1_reg        <= t1_next;
        t2_reg        <= t2_next;
        dma_reg       <= dma_next;
        neg_reg       <= neg_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        pm_major_reg  <= pm_major_next;
        pm_minor_reg  <= pm_minor_next;
        pm_gap_reg    <= pm_gap_next;
        pm_last_reg   <= pm_last_next;
        w0_reg        <= w0_next;
        w1_reg        <= w1_next;
        a0_reg        <= a0_next;
        a1_reg        <= a1_next;
    end

    // second pixel of the pair sits one step further along the minor axis
    always_comb begin
        base     = pm_minor_reg[28:16];
        px_minor = (state_reg == aaline_pkg::S_SEND1) ? base + PW'(1) : base;
        px_x     = steep_reg ? px_minor : pm_major_reg;
        px_y     = steep_reg ? pm_major_reg : px_minor;
    end

    assign s_tready = (state_reg == aaline_pkg::S_IDLE);
    assign m_tvalid = (state_reg == aaline_pkg::S_SEND0) || (state_reg == aaline_pkg::S_SEND1);
    assign m_tdata  = {6'b0,
                       (state_reg == aaline_pkg::S_SEND1) ? a1_reg : a0_reg,
                       colour_reg[23:0], px_y, px_x};
    assign m_tlast  = (state_reg == aaline_pkg::S_SEND1) && pm_last_reg;

endmodule

>>> test/tb_antialiased_line_pixel_generator.sv
// tb_antialiased_line_pixel_generator: random and directed test of the wu line pixel generator
// depends on aaline_pkg and antialiased_line_pixel_generator; checks every output word
// against a behavioral predictor of the pixel pairs
`timescale 1ns / 100ps

module tb_antialiased_line_pixel_generator;

    // one input word as the driver sees it
    typedef struct {
        logic        kind;
        logic [15:0] xs, ys, xe, ye;
        logic [7:0]  r, g, b, a;
    } line_cmd_t;

    // one expected pixel
    typedef struct {
        logic signed [12:0] px, py;
        logic [7:0]         r, g, b, a;
        logic               last;
    } pixel_t;

    logic        aclk, aresetn;
    logic        s_tvalid, s_tready, s_tuser;
    logic [95:0] s_tdata;
    logic        m_tvalid, m_tready, m_tlast;
    logic [63:0] m_tdata;

    line_cmd_t cmd_queue[$];
    pixel_t    pixel_queue[$];
    int        err_cnt = 0;
    int        word_cnt = 0;     // accepted input words, drives the no-idle stretch
    bit        stim_done = 0;

    // predictor state
    bit          act, steep, far_pend;
    longint      cur_col, stop_col, minor_q, grad_q, far_minor;
    longint      far_gap;
    logic [31:0] colour;

    antialiased_line_pixel_generator i_dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // floor division by a power of two
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void push_pixel(longint major, longint minor, longint w, bit last);
        pixel_t p;
        p.px   = 13'(steep ? minor : major);
        p.py   = 13'(steep ? major : minor);
        p.r    = colour[7:0];
        p.g    = colour[15:8];
        p.b    = colour[23:16];
        p.a    = 8'((longint'(colour[31:24]) * w) >> aaline_pkg::COVER_BITS);
        p.last = last;
        pixel_queue.push_back(p);
    endfunction

    function automatic void push_pair(longint major, longint mq, longint gap, bit last);
        longint base, f, rf;
        base = floor_shift(mq, aaline_pkg::SLOPE_FRAC);
        f    = (mq & ((64'd1 << aaline_pkg::SLOPE_FRAC) - 1))
               >> (aaline_pkg::SLOPE_FRAC - aaline_pkg::COVER_BITS);
        rf   = (1 << aaline_pkg::COVER_BITS) - f;
        push_pixel(major, base, (rf * gap) >> aaline_pkg::COVER_BITS, 0);
        push_pixel(major, base + 1, (f * gap) >> aaline_pkg::COVER_BITS, last);
    endfunction

    // expected pixels for one accepted word
    function automatic void predict_pixels(line_cmd_t c);
        longint x1, y1, x2, y2, ma1, mi1, ma2, mi2, t, dma, gr, r1, r2, mq1, mq2, half;
        bit interior, done;
        half = 1 << (aaline_pkg::COORD_FRAC - 1);
        if (c.kind == aaline_pkg::kind_start) begin
            x1 = $signed(c.xs); y1 = $signed(c.ys);
            x2 = $signed(c.xe); y2 = $signed(c.ye);
            // tie in |dx| and |dy| goes to y as the major axis
            steep = !((x2 > x1 ? x2 - x1 : x1 - x2) > (y2 > y1 ? y2 - y1 : y1 - y2));
            ma1 = steep ? y1 : x1; mi1 = steep ? x1 : y1;
            ma2 = steep ? y2 : x2; mi2 = steep ? x2 : y2;
            if (ma2 < ma1) begin
                t = ma1; ma1 = ma2; ma2 = t;
                t = mi1; mi1 = mi2; mi2 = t;
            end
            dma = ma2 - ma1;
            // zero-length line keeps gradient 0; division truncates toward zero
            gr = (dma > 0) ? ((mi2 - mi1) * (64'sd1 <<< aaline_pkg::SLOPE_FRAC)) / dma : 0;
            colour = {c.a, c.b, c.g, c.r};
            r1  = floor_shift(ma1 + half, aaline_pkg::COORD_FRAC);
            mq1 = mi1 * (1 << (aaline_pkg::SLOPE_FRAC - aaline_pkg::COORD_FRAC))
                + floor_shift(gr * (r1 * (1 << aaline_pkg::COORD_FRAC) - ma1),
                              aaline_pkg::COORD_FRAC);
            push_pair(r1, mq1, (1 << aaline_pkg::COVER_BITS)
                - (((ma1 + half) & ((1 << aaline_pkg::COORD_FRAC) - 1))
                   << (aaline_pkg::COVER_BITS - aaline_pkg::COORD_FRAC)), 0);
            r2  = floor_shift(ma2 + half, aaline_pkg::COORD_FRAC);
            mq2 = mi2 * (1 << (aaline_pkg::SLOPE_FRAC - aaline_pkg::COORD_FRAC))
                + floor_shift(gr * (r2 * (1 << aaline_pkg::COORD_FRAC) - ma2),
                              aaline_pkg::COORD_FRAC);
            grad_q    = gr;
            minor_q   = mq1 + gr;
            far_minor = mq2;
            far_gap   = ((ma2 + half) & ((1 << aaline_pkg::COORD_FRAC) - 1))
                        << (aaline_pkg::COVER_BITS - aaline_pkg::COORD_FRAC);
            cur_col   = r1 + 1;
            stop_col  = r2;
            far_pend  = 1;
            act       = 1;
        end else if (act) begin
            if (far_pend) begin
                interior = cur_col <= stop_col - 1;
                far_pend = 0;
                push_pair(stop_col, far_minor, far_gap, !interior);
                if (!interior) act = 0;
            end else begin
                t = cur_col;
                mi1 = minor_q;
                minor_q += grad_q;
                cur_col += 1;
                done = cur_col > stop_col - 1;
                push_pair(t, mi1, 1 << aaline_pkg::COVER_BITS, done);
                if (done) act = 0;
            end
        end
    endfunction

    function automatic line_cmd_t make_line(logic [15:0] xs, ys, xe, ye, logic [31:0] rgba);
        line_cmd_t c;
        c.kind = aaline_pkg::kind_start;
        c.xs = xs; c.ys = ys; c.xe = xe; c.ye = ye;
        {c.a, c.b, c.g, c.r} = rgba;
        return c;
    endfunction

    function automatic line_cmd_t make_advance(bit noise);
        line_cmd_t c;
        c = make_line(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        c.kind = aaline_pkg::kind_advance;
        if (!noise) begin
            c.xs = 0; c.ys = 0; c.xe = 0; c.ye = 0;
            {c.a, c.b, c.g, c.r} = 0;
        end
        return c;
    endfunction

    // random coordinate: mostly near each other so lines stay short
    function automatic logic [15:0] near_coord(logic [15:0] base);
        return base + 16'($signed($urandom_range(0, 320)) - 160);
    endfunction

    // queue a line, enough advances to drain it and the given number of extra advances
    task automatic queue_line(line_cmd_t c, int extra);
        longint span;
        int n;
        span = 2 + (($signed(c.xe) > $signed(c.xs) ? $signed(c.xe) - $signed(c.xs)
                                                     : $signed(c.xs) - $signed(c.xe)) +
                    ($signed(c.ye) > $signed(c.ys) ? $signed(c.ye) - $signed(c.ys)
                                                     : $signed(c.ys) - $signed(c.ye))) / 16;
        n = int'(span) + extra;
        cmd_queue.push_back(c);
        repeat (n) cmd_queue.push_back(make_advance($urandom_range(0, 3) == 0));
    endtask

    initial begin
        line_cmd_t c;
        logic [15:0] b0, b1;
        int cut;
        // advance before any line: no pixels
        cmd_queue.push_back(make_advance(1));
        // directed lines: extremes, zero length, ties, steep and shallow, both directions
        queue_line(make_line(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'hffffffff), 2);
        queue_line(make_line(16'h0010, 16'h0018, 16'h0058, 16'h0037, 32'h80402010), 1);
        queue_line(make_line(16'h0047, 16'h0003, 16'h0003, 16'h0029, 32'hff00ff00), 1);
        queue_line(make_line(16'h0000, 16'h0000, 16'h0030, 16'h0030, 32'h00ff00ff), 1);
        queue_line(make_line(16'h8000, 16'h8000, 16'h8038, 16'h801f, 32'hffffffff), 0);
        queue_line(make_line(16'h7fff, 16'h7fff, 16'h7fc8, 16'h7ff1, 32'h7f7f7f7f), 0);
        // full-range steep line, only its first pixels are walked
        cmd_queue.push_back(make_line(16'h7ff8, 16'h8008, 16'h7fe1, 16'h7fff, 32'h01010101));
        repeat (8) cmd_queue.push_back(make_advance(0));
        // start while a line is active drops the old line
        cmd_queue.push_back(make_line(16'h0000, 16'h0000, 16'h0100, 16'h0040, 32'h12345678));
        cmd_queue.push_back(make_advance(0));
        queue_line(make_line(16'hfff1, 16'hffe7, 16'h0022, 16'hfffb, 32'hffffff00), 0);
        // random part: mostly complete short lines, some truncated, some noise
        while (cmd_queue.size() < 1000) begin
            b0 = 16'(int'($urandom_range(0, 65152)) - 32576);
            b1 = 16'(int'($urandom_range(0, 65152)) - 32576);
            if ($urandom_range(0, 9) == 0) begin
                b0 = $urandom_range(0, 1) ? 16'h7f40 : 16'h80c0;
                b1 = $urandom_range(0, 1) ? 16'h7f40 : 16'h80c0;
            end
            c = make_line(b0, b1, near_coord(b0), near_coord(b1), $urandom);
            cut = $urandom_range(0, 7);
            if (cut == 0) cmd_queue.push_back(c);
            else queue_line(c, (cut == 1) ? 2 : 0);
        end
        stim_done = 1;
    end

    // driver: feeds words from the queue, idles on about 21 of 100 draws outside the no-idle stretch
    always @(posedge aclk) begin
        line_cmd_t c;
        bit        idle;
        if (!aresetn) begin
            s_tvalid <= 0;
            s_tuser  <= 0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixels(cmd_queue.pop_front());
                word_cnt++;
            end
            // no-idle stretch in the middle of the run
            idle = (word_cnt < 300 || word_cnt > 500) && ($urandom_range(0, 99) < 21);
            if ((!s_tvalid || s_tready) && cmd_queue.size() > 0 && !idle) begin
                c = cmd_queue[0];
                s_tvalid <= 1;
                s_tuser  <= c.kind;
                s_tdata  <= {c.a, c.b, c.g, c.r, c.ye, c.xe, c.ys, c.xs};
            end else if (!s_tvalid || s_tready) begin
                s_tvalid <= 0;
            end
        end
    end

    // monitor: compare each output word with the oldest expected pixel
    always @(posedge aclk) begin
        pixel_t e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixel_queue.size() == 0) begin
                    $error("unexpected pixel word %h", m_tdata);
                    err_cnt++;
                end else begin
                    e = pixel_queue.pop_front();
                    if (m_tdata[12:0] !== e.px) begin
                        $error("pixel_x exp %0d got %0d", e.px, $signed(m_tdata[12:0]));
                        err_cnt++;
                    end
                    if (m_tdata[25:13] !== e.py) begin
                        $error("pixel_y exp %0d got %0d", e.py, $signed(m_tdata[25:13]));
                        err_cnt++;
                    end
                    if (m_tdata[33:26] !== e.r) begin
                        $error("pixel_red exp %0d got %0d", e.r, m_tdata[33:26]);
                        err_cnt++;
                    end
                    if (m_tdata[41:34] !== e.g) begin
                        $error("pixel_green exp %0d got %0d", e.g, m_tdata[41:34]);
                        err_cnt++;
                    end
                    if (m_tdata[49:42] !== e.b) begin
                        $error("pixel_blue exp %0d got %0d", e.b, m_tdata[49:42]);
                        err_cnt++;
                    end
                    if (m_tdata[57:50] !== e.a) begin
                        $error("pixel_alpha exp %0d got %0d", e.a, m_tdata[57:50]);
                        err_cnt++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_pixel exp %0d got %0d", e.last, m_tlast);
                        err_cnt++;
                    end
                end
            end
            m_tready <= (word_cnt >= 300 && word_cnt <= 500) || ($urandom_range(0, 99) >= 21);
        end
    end

    // reset, then wait for the stimulus to drain and the output to settle
    initial begin
        aresetn = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        while (!(stim_done && cmd_queue.size() == 0 && pixel_queue.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);
        if (err_cnt == 0 && pixel_queue.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog: ends a run of ~1000 words that has not drained, as a mismatch
    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
